FILE: hw/rtl/hyst_pkg.sv
// Shared types and constants for the hysteresis threshold block.
package hyst_pkg;

    localparam int PIX_W  = 8;
    localparam int HIGH_W = 9;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;

    // Pixel classes kept in the line store and the window.
    typedef enum logic [1:0] {
        CLS_ZERO   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } t_cls;

    // Input item kinds.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_LOW_THR  = 2'd0,
        REG_HIGH_THR = 2'd1,
        REG_WIDTH    = 2'd2,
        REG_HEIGHT   = 2'd3
    } t_reg_idx;

    localparam logic [PIX_W-1:0]  RST_LOW_THR  = 8'd50;
    localparam logic [HIGH_W-1:0] RST_HIGH_THR = 9'd100;
    localparam logic [CFG_W-1:0]  RST_WIDTH    = 11'd640;
    localparam logic [CFG_W-1:0]  RST_HEIGHT   = 11'd480;

endpackage

FILE: hw/rtl/hyst_in_if.sv
// Input channel: raster pixels and flush items.
interface hyst_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [hyst_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

FILE: hw/rtl/hyst_out_if.sv
// Output channel: thresholded pixels with end-of-frame marker.
interface hyst_out_if;
    logic                      valid;
    logic                      ready;
    logic [hyst_pkg::PIX_W-1:0] out_pixel;
    logic                      end_of_frame;

    modport source (output valid, output out_pixel, output end_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input end_of_frame, output ready);
endinterface

FILE: hw/rtl/hyst_linebuf.sv
// Two-row class line store with registered read and write-to-read forwarding.
module hyst_linebuf #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  hyst_pkg::t_cls   i_wr_upper,
    input  hyst_pkg::t_cls   i_wr_middle,
    output hyst_pkg::t_cls   o_upper,
    output hyst_pkg::t_cls   o_middle
);

    // Each entry holds {upper row class, middle row class} of one column.
    logic [3:0]    r_mem [DEPTH];
    logic [3:0]    r_rd_data;
    logic [AW-1:0] r_rd_addr;
    logic          r_last_vld;
    logic [AW-1:0] r_last_addr;
    logic [3:0]    r_last_data;
    logic [3:0]    rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_upper, i_wr_middle};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_last_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_last_addr <= i_wr_addr;
            r_last_data <= {i_wr_upper, i_wr_middle};
        end
    end

    // The most recent write is the newest copy of its column, so it may be
    // forwarded whether it landed at the read edge or earlier.
    always_comb begin
        if (r_last_vld && (r_last_addr == r_rd_addr)) begin
            rd_word = r_last_data;
        end else begin
            rd_word = r_rd_data;
        end
    end

    assign o_upper  = hyst_pkg::t_cls'(rd_word[3:2]);
    assign o_middle = hyst_pkg::t_cls'(rd_word[1:0]);

endmodule

FILE: hw/rtl/hysteresis_threshold_3x3_top.sv
// Hysteresis threshold over a 3x3 class window, streamed in raster order.
// The block takes one item per clock unless stalled and gives at most one
// result per clock. Results trail the pixel stream by image_width + 1 items; a
// pixel transaction yields a result once that many are owed, and each flush
// transaction drains one owed result (a flush with nothing owed yields none).
// Released results pass the work stage, then the output register. The class
// line store is a single-port-write, single-port-read memory of MAX_WIDTH
// entries; its content is undefined after reset and needs no clearing pass,
// since columns never written only feed neighbors that lie outside the image.
module hysteresis_threshold_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hyst_in_if.sink                           i_in,
    hyst_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [hyst_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [hyst_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [hyst_pkg::PIX_W-1:0]  r_low_thr;
    logic [hyst_pkg::HIGH_W-1:0] r_high_thr;
    logic [hyst_pkg::CFG_W-1:0]  r_width;
    logic [hyst_pkg::CFG_W-1:0]  r_height;

    // Position counters.
    logic [CW-1:0] r_icol;
    logic [CW-1:0] r_ocol;
    logic [RW-1:0] r_orow;
    logic [PW-1:0] r_pend;

    // Work stage.
    logic           r_s2_vld;
    logic           r_s2_emit;
    logic [CW-1:0]  r_s2_col;
    hyst_pkg::t_cls r_s2_cls;
    logic           r_s2_top_ok;
    logic           r_s2_bot_ok;
    logic           r_s2_left_ok;
    logic           r_s2_right_ok;
    logic           r_s2_eof;

    hyst_pkg::t_cls r_win [3][3];
    hyst_pkg::t_cls n_win [3][3];

    // Output register.
    logic                       r_out_vld;
    logic [hyst_pkg::PIX_W-1:0] r_out_pixel;
    logic                       r_out_eof;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [CW-1:0]  ic_eff;
    logic [CW-1:0]  oc_eff;
    logic [RW-1:0]  or_eff;
    logic           ic_last;
    logic           oc_last;
    logic           or_last;
    logic           is_flush;
    logic           pend_any;
    logic           emit;
    logic           in_fire;
    logic           work;
    logic [CW-1:0]  col;
    hyst_pkg::t_cls cls;
    logic           out_free;
    logic           s2_go;
    hyst_pkg::t_cls lb_upper;
    hyst_pkg::t_cls lb_middle;
    logic           nb_strong;
    hyst_pkg::t_cls centre;
    logic [hyst_pkg::PIX_W-1:0] res_pixel;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= hyst_pkg::RST_LOW_THR;
            r_high_thr <= hyst_pkg::RST_HIGH_THR;
            r_width    <= hyst_pkg::RST_WIDTH;
            r_height   <= hyst_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hyst_pkg::REG_LOW_THR:  r_low_thr  <= i_cfg_data[hyst_pkg::PIX_W-1:0];
                hyst_pkg::REG_HIGH_THR: r_high_thr <= i_cfg_data[hyst_pkg::HIGH_W-1:0];
                hyst_pkg::REG_WIDTH:    r_width    <= i_cfg_data;
                hyst_pkg::REG_HEIGHT:   r_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero is taken as one, oversize values are clamped to MAX_WIDTH and MAX_HEIGHT.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
    end

    // ---------------- acceptance side ----------------
    // Counters left beyond a reduced frame size read as zero.
    assign ic_eff  = (WW'(r_icol) >= w_eff) ? '0 : r_icol;
    assign oc_eff  = (WW'(r_ocol) >= w_eff) ? '0 : r_ocol;
    assign or_eff  = (HW'(r_orow) >= h_eff) ? '0 : r_orow;
    assign ic_last = (WW'(ic_eff) == w_eff - WW'(1));
    assign oc_last = (WW'(oc_eff) == w_eff - WW'(1));
    assign or_last = (HW'(or_eff) == h_eff - HW'(1));

    assign is_flush = (i_in.op == hyst_pkg::OP_FLUSH);
    assign pend_any = (r_pend != '0);
    assign emit     = is_flush ? pend_any : (r_pend >= PW'(w_eff) + PW'(1));

    assign out_free   = !r_out_vld || o_out.ready;
    assign s2_go      = r_s2_vld && (!r_s2_emit || out_free);
    assign i_in.ready = !r_s2_vld || s2_go;
    assign in_fire    = i_in.valid && i_in.ready;
    assign work       = in_fire && (!is_flush || pend_any);

    // A flush shifts a zero-class stand-in in at the column after the output.
    always_comb begin
        if (is_flush) begin
            col = oc_last ? '0 : oc_eff + CW'(1);
            cls = hyst_pkg::CLS_ZERO;
        end else begin
            col = ic_eff;
            if (i_in.pixel <= r_low_thr) begin
                cls = hyst_pkg::CLS_ZERO;
            end else if ((hyst_pkg::HIGH_W'(i_in.pixel) >= r_high_thr) ||
                         (i_in.pixel == hyst_pkg::PIX_MAX)) begin
                cls = hyst_pkg::CLS_STRONG;
            end else begin
                cls = hyst_pkg::CLS_WEAK;
            end
        end
    end

    // Every accepted transaction stores the wrapped counters, so a later size
    // change starts from the same positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_pend <= '0;
        end else if (in_fire) begin
            if (work && !is_flush) begin
                r_icol <= ic_last ? '0 : ic_eff + CW'(1);
            end else begin
                r_icol <= ic_eff;
            end
            if (work && emit) begin
                if (oc_last) begin
                    r_ocol <= '0;
                    r_orow <= or_last ? '0 : or_eff + RW'(1);
                end else begin
                    r_ocol <= oc_eff + CW'(1);
                    r_orow <= or_eff;
                end
            end else begin
                r_ocol <= oc_eff;
                r_orow <= or_eff;
            end
            if (work) begin
                if (is_flush) begin
                    r_pend <= r_pend - PW'(1);
                end else if (!emit) begin
                    r_pend <= r_pend + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (work) begin
            r_s2_vld <= 1'b1;
        end else if (s2_go) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_s2_emit     <= emit;
            r_s2_col      <= col;
            r_s2_cls      <= cls;
            r_s2_top_ok   <= (or_eff != '0);
            r_s2_bot_ok   <= !or_last;
            r_s2_left_ok  <= (oc_eff != '0);
            r_s2_right_ok <= !oc_last;
            r_s2_eof      <= or_last && oc_last;
        end
    end

    // ---------------- line store ----------------
    hyst_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (work),
        .i_rd_addr   (col),
        .i_wr_en     (s2_go),
        .i_wr_addr   (r_s2_col),
        .i_wr_upper  (lb_middle),
        .i_wr_middle (r_s2_cls),
        .o_upper     (lb_upper),
        .o_middle    (lb_middle)
    );

    // ---------------- window and decision ----------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = lb_upper;
        n_win[1][2] = lb_middle;
        n_win[2][2] = r_s2_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= hyst_pkg::CLS_ZERO;
                end
            end
        end else if (s2_go) begin
            r_win <= n_win;
        end
    end

    // The result is always taken at the middle column of the shifted window;
    // at the end of a row the right column is masked as outside the image.
    assign centre = n_win[1][1];

    always_comb begin
        nb_strong =
            (r_s2_top_ok &&
                ((r_s2_left_ok  && (n_win[0][0] == hyst_pkg::CLS_STRONG)) ||
                 (n_win[0][1] == hyst_pkg::CLS_STRONG) ||
                 (r_s2_right_ok && (n_win[0][2] == hyst_pkg::CLS_STRONG)))) ||
            (r_s2_left_ok  && (n_win[1][0] == hyst_pkg::CLS_STRONG)) ||
            (r_s2_right_ok && (n_win[1][2] == hyst_pkg::CLS_STRONG)) ||
            (r_s2_bot_ok &&
                ((r_s2_left_ok  && (n_win[2][0] == hyst_pkg::CLS_STRONG)) ||
                 (n_win[2][1] == hyst_pkg::CLS_STRONG) ||
                 (r_s2_right_ok && (n_win[2][2] == hyst_pkg::CLS_STRONG))));
    end

    always_comb begin
        unique case (centre)
            hyst_pkg::CLS_ZERO:   res_pixel = hyst_pkg::PIX_ZERO;
            hyst_pkg::CLS_STRONG: res_pixel = hyst_pkg::PIX_MAX;
            hyst_pkg::CLS_WEAK:   res_pixel = nb_strong ? hyst_pkg::PIX_MAX
                                                        : hyst_pkg::PIX_ZERO;
            default:              res_pixel = hyst_pkg::PIX_ZERO;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_go && r_s2_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_s2_emit) begin
            r_out_pixel <= res_pixel;
            r_out_eof   <= r_s2_eof;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.out_pixel    = r_out_pixel;
    assign o_out.end_of_frame = r_out_eof;

endmodule

FILE: hw/rtl/hyst_checker.sv
// Port-level checks on the result channel, bound to the top level.
module hyst_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [hyst_pkg::PIX_W-1:0] i_out_pixel,
    input logic                       i_out_eof
);

    // A result pixel is binary: black or white.
    a_binary_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_pixel == hyst_pkg::PIX_ZERO) ||
                        (i_out_pixel == hyst_pkg::PIX_MAX))
        else $error("result pixel is neither black nor white");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_pixel) && $stable(i_out_eof)))
        else $error("result payload changed while stalled");

endmodule

bind hysteresis_threshold_3x3_top hyst_checker u_hyst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pixel (o_out.out_pixel),
    .i_out_eof   (o_out.end_of_frame)
);
